// ===== sv/rtex_pkg.sv =====
// ============================================================================
// rtex_pkg - shared definitions of the replacement template expander
// Sizes of the stores, input kind codes and the records passed between the
// escape parser and the copy sequencer.
// ============================================================================
package rtex_pkg;

    // Store sizes
    localparam int unsigned TEXT_DEPTH  = 32;
    localparam int unsigned GROUP_SLOTS = 100;
    localparam int unsigned MAX_COPY    = 32;

    // Address widths of the two memories
    localparam int unsigned TA_W = $clog2(TEXT_DEPTH);
    localparam int unsigned GA_W = $clog2(GROUP_SLOTS);

    // Offset width, set by the span end field
    localparam int unsigned PTR_W = 6;

    // Span memory word: start in the upper bits, end in the lower bits
    localparam int unsigned START_W = 7;
    localparam int unsigned SPAN_W  = START_W + PTR_W;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_SPAN = 2'd1,
        KIND_TMPL = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    // One result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        logic       error;
    } t_result;

    // Parser decision for the current item: an optional group copy,
    // followed by an optional result
    typedef struct packed {
        logic       copy;
        logic [6:0] group;
        logic       res_valid;
        t_result    res;
    } t_parse_act;

endpackage

// ===== sv/replacement_template_expander_unit.sv =====
// ============================================================================
// replacement_template_expander_unit - regex replacement template expander
// Stores the matched text and group spans, then expands a template stream
// into output bytes, copying group spans for backreferences.
// ============================================================================
// Load the matched text (kind 0) and group spans (kind 1) first, write the
// group count register while idle, then stream template bytes (kind 2) and
// close with an end item (kind 3), which returns one result with tlast set
// and the sticky error flag in tuser. Load items, plain bytes and escapes
// take one cycle each while the output side is ready. A backreference item is
// taken and its span is read and checked, then the copy sends one byte per
// cycle while the output side is ready, paced by the single read port of
// the text memory, and a closing state follows, which also sends the byte
// or final result that follows the copy when there is one. The stores
// need no clearing after reset; reading text or spans that were never
// loaded gives unspecified bytes.
module replacement_template_expander_unit
    import rtex_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: groups_in_use
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] text_byte, [12:8] text_index, [19:13] group_index,
    // [26:20] group_start, [32:27] group_end, [40:33] template_byte
    input  logic [47:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  m_axis_tdata,
    // [0] has_byte, [1] error
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SPAN = 5'b00010,
        ST_COPY = 5'b00100,
        ST_TAIL = 5'b01000,
        ST_HOLD = 5'b10000
    } t_state;

    localparam logic [PTR_W-1:0] TEXT_LIM = PTR_W'(TEXT_DEPTH);
    localparam logic [PTR_W-1:0] COPY_LIM = PTR_W'(MAX_COPY);

    // Input fields
    t_kind        kind;
    logic [7:0]   text_byte;
    logic [4:0]   text_index;
    logic [6:0]   group_index;
    logic [6:0]   group_start;
    logic [5:0]   group_end;
    logic [7:0]   template_byte;

    assign kind          = t_kind'(s_axis_tuser);
    assign text_byte     = s_axis_tdata[7:0];
    assign text_index    = s_axis_tdata[12:8];
    assign group_index   = s_axis_tdata[19:13];
    assign group_start   = s_axis_tdata[26:20];
    assign group_end     = s_axis_tdata[32:27];
    assign template_byte = s_axis_tdata[40:33];

    t_state           r_state, n_state;
    logic [6:0]       r_groups;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic             r_tail_valid, n_tail_valid;
    t_result          r_tail, n_tail;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [PTR_W-1:0] r_hi, n_hi;
    logic [PTR_W-1:0] r_cnt, n_cnt;

    logic             accept;
    logic             out_free;
    t_parse_act       act;

    logic             text_we, text_re;
    logic [TA_W-1:0]  text_raddr;
    logic [7:0]       text_rdata;
    logic             span_we, span_re;
    logic [GA_W-1:0]  span_raddr;
    logic [SPAN_W-1:0] span_rdata;

    logic [START_W-1:0] sp_start;
    logic [PTR_W-1:0]   sp_end;
    logic [PTR_W-1:0]   sp_hi;
    logic [PTR_W-1:0]   ptr_next;
    logic [PTR_W-1:0]   cnt_next;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign sp_start = span_rdata[SPAN_W-1:PTR_W];
    assign sp_end   = span_rdata[PTR_W-1:0];
    assign sp_hi    = (sp_end < TEXT_LIM) ? sp_end : TEXT_LIM;
    assign ptr_next = PTR_W'(r_ptr + 1'b1);
    assign cnt_next = PTR_W'(r_cnt + 1'b1);

    // Escape parser
    rtex_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tmpl   (accept && kind == KIND_TMPL),
        .i_end    (accept && kind == KIND_END),
        .i_byte   (template_byte),
        .i_groups (r_groups),
        .o_act    (act)
    );

    // Matched text store
    rtex_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (text_we),
        .i_waddr (text_index[TA_W-1:0]),
        .i_wdata (text_byte),
        .i_re    (text_re),
        .i_raddr (text_raddr),
        .o_rdata (text_rdata)
    );

    // Group span store
    rtex_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (GROUP_SLOTS)
    ) u_span_ram (
        .i_clk   (i_clk),
        .i_we    (span_we),
        .i_waddr (group_index[GA_W-1:0]),
        .i_wdata ({group_start, group_end}),
        .i_re    (span_re),
        .i_raddr (span_raddr),
        .o_rdata (span_rdata)
    );

    // Sequencer: take items, fetch spans, copy text, then send the tail result
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out        = r_out;
        n_tail_valid = r_tail_valid;
        n_tail       = r_tail;
        n_ptr        = r_ptr;
        n_hi         = r_hi;
        n_cnt        = r_cnt;
        text_we      = 1'b0;
        text_re      = 1'b0;
        text_raddr   = r_ptr[TA_W-1:0];
        span_we      = 1'b0;
        span_re      = 1'b0;
        span_raddr   = act.group[GA_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_TEXT: begin
                            text_we = (32'(text_index) < TEXT_DEPTH);
                        end
                        KIND_SPAN: begin
                            span_we = (32'(group_index) < GROUP_SLOTS);
                        end
                        KIND_TMPL, KIND_END: begin
                            if (act.copy) begin
                                span_re      = 1'b1;
                                n_tail       = act.res;
                                n_tail_valid = act.res_valid;
                                n_state      = ST_SPAN;
                            end else if (act.res_valid) begin
                                n_out       = act.res;
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SPAN: begin
                // skip a group that did not match or an empty span
                if (!sp_start[START_W-1] && sp_start[PTR_W-1:0] < sp_hi) begin
                    text_re    = 1'b1;
                    text_raddr = sp_start[TA_W-1:0];
                    n_ptr      = sp_start[PTR_W-1:0];
                    n_hi       = sp_hi;
                    n_cnt      = '0;
                    n_state    = ST_COPY;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_COPY: begin
                if (out_free) begin
                    n_out.out_byte = text_rdata;
                    n_out.has_byte = 1'b1;
                    n_out.last     = 1'b0;
                    n_out.error    = 1'b0;
                    n_out_valid    = 1'b1;
                    if (ptr_next < r_hi && cnt_next < COPY_LIM) begin
                        text_re    = 1'b1;
                        text_raddr = ptr_next[TA_W-1:0];
                        n_ptr      = ptr_next;
                        n_cnt      = cnt_next;
                    end else begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                if (!r_tail_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out        = r_tail;
                    n_out_valid  = 1'b1;
                    n_tail_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_groups     <= 7'd1;
            r_out_valid  <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_tail_valid <= n_tail_valid;
            if (i_cfg_wr_en) begin
                r_groups <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_tail <= n_tail;
        r_ptr  <= n_ptr;
        r_hi   <= n_hi;
        r_cnt  <= n_cnt;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.out_byte;
    assign m_axis_tuser  = {r_out.error, r_out.has_byte};
    assign m_axis_tlast  = r_out.last;

endmodule

// ===== sv/rtex_ram.sv =====
// ============================================================================
// rtex_ram - generic single write, single read memory
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ============================================================================
module rtex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rtex_parse.sv =====
// ============================================================================
// rtex_parse - escape parser of the template stream
// Holds the parse phase, digit accumulator, first reference digit and the
// sticky error flag, and decides per template or end item what to emit and
// which group to copy.
// ============================================================================
module rtex_parse
    import rtex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tmpl,
    input  logic       i_end,
    input  logic [7:0] i_byte,
    input  logic [6:0] i_groups,
    output t_parse_act o_act
);

    // Characters the parser looks at
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CC_BEL    = 8'h07;
    localparam logic [7:0] CC_BS     = 8'h08;
    localparam logic [7:0] CC_TAB    = 8'h09;
    localparam logic [7:0] CC_LF     = 8'h0A;
    localparam logic [7:0] CC_VT     = 8'h0B;
    localparam logic [7:0] CC_FF     = 8'h0C;
    localparam logic [7:0] CC_CR     = 8'h0D;

    localparam logic [6:0] SLOTS = 7'(GROUP_SLOTS);

    typedef enum logic [7:0] {
        PH_PLAIN = 8'b0000_0001,
        PH_ESC   = 8'b0000_0010,
        PH_OCT1  = 8'b0000_0100,
        PH_OCT2  = 8'b0000_1000,
        PH_OCT3  = 8'b0001_0000,
        PH_HEX1  = 8'b0010_0000,
        PH_HEX2  = 8'b0100_0000,
        PH_REF2  = 8'b1000_0000
    } t_phase;

    // Simple character escape: {known, translated byte}
    function automatic logic [8:0] esc_char(input logic [7:0] b);
        logic [8:0] r;
        unique case (b)
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_SQUOTE: r = {1'b1, CH_SQUOTE};
            CH_DQUOTE: r = {1'b1, CH_DQUOTE};
            CH_LA:     r = {1'b1, CC_BEL};
            CH_LB:     r = {1'b1, CC_BS};
            CH_LF:     r = {1'b1, CC_FF};
            CH_LN:     r = {1'b1, CC_LF};
            CH_LR:     r = {1'b1, CC_CR};
            CH_LT:     r = {1'b1, CC_TAB};
            CH_LV:     r = {1'b1, CC_VT};
            default:   r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

    // Hex digit: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    t_phase     r_phase, n_phase;
    logic [7:0] r_acc, n_acc;
    logic [3:0] r_first, n_first;
    logic       r_err, n_err;

    logic [6:0] limit;
    logic       is_digit;
    logic [6:0] two_digit;
    logic [8:0] esc;
    logic [4:0] hex;
    logic [7:0] oct_acc;
    logic [7:0] hex_acc;
    t_parse_act act;

    assign limit     = (i_groups < SLOTS) ? i_groups : SLOTS;
    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign two_digit = 7'(7'(r_first) * 7'd10 + 7'(i_byte[3:0]));
    assign esc       = esc_char(i_byte);
    assign hex       = hex_digit(i_byte);
    assign oct_acc   = {r_acc[4:0], i_byte[2:0]};
    assign hex_acc   = (r_phase == PH_HEX1) ? {4'd0, hex[3:0]} : {r_acc[3:0], hex[3:0]};

    // Decide the action and the next parse state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_first = r_first;
        n_err   = r_err;
        act     = '0;
        act.res.has_byte = 1'b1;
        act.res.out_byte = i_byte;

        if (i_tmpl) begin
            unique case (r_phase)
                PH_PLAIN: begin
                    if (i_byte == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        act.res_valid = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_PLAIN;
                    if (esc[8]) begin
                        act.res_valid    = 1'b1;
                        act.res.out_byte = esc[7:0];
                    end else if (i_byte == CH_ZERO) begin
                        n_phase = PH_OCT1;
                    end else if (i_byte == CH_LX || i_byte == CH_UX) begin
                        n_phase = PH_HEX1;
                    end else if (i_byte >= CH_ONE && i_byte <= CH_NINE) begin
                        n_first = i_byte[3:0];
                        n_phase = PH_REF2;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_OCT1: begin
                    if (i_byte >= CH_ZERO && i_byte <= CH_THREE) begin
                        n_acc   = {6'd0, i_byte[1:0]};
                        n_phase = PH_OCT2;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_PLAIN;
                    end
                end
                PH_OCT2, PH_OCT3: begin
                    if (i_byte >= CH_ZERO && i_byte <= CH_SEVEN) begin
                        n_acc = oct_acc;
                        if (r_phase == PH_OCT3) begin
                            act.res_valid    = 1'b1;
                            act.res.out_byte = oct_acc;
                            n_phase          = PH_PLAIN;
                        end else begin
                            n_phase = PH_OCT3;
                        end
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_PLAIN;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hex[4]) begin
                        n_err   = 1'b1;
                        n_phase = PH_PLAIN;
                    end else begin
                        n_acc = hex_acc;
                        if (r_phase == PH_HEX1) begin
                            n_phase = PH_HEX2;
                        end else begin
                            act.res_valid    = 1'b1;
                            act.res.out_byte = hex_acc;
                            n_phase          = PH_PLAIN;
                        end
                    end
                end
                PH_REF2: begin
                    n_phase = PH_PLAIN;
                    if (is_digit) begin
                        act.group = two_digit;
                    end else begin
                        act.group = 7'(r_first);
                        // the byte after a one-digit reference is handled as plain text; a backslash starts an escape
                        if (i_byte == CH_BSLASH) begin
                            n_phase = PH_ESC;
                        end else begin
                            act.res_valid = 1'b1;
                        end
                    end
                    if (act.group < limit) begin
                        act.copy = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_PLAIN;
                end
            endcase
        end else if (i_end) begin
            // Final result; finish a pending one-digit reference first
            act.res_valid    = 1'b1;
            act.res.out_byte = 8'd0;
            act.res.has_byte = 1'b0;
            act.res.last     = 1'b1;
            act.group        = 7'(r_first);
            act.res.error    = r_err;
            if (r_phase == PH_REF2) begin
                if (act.group < limit) begin
                    act.copy = 1'b1;
                end else begin
                    act.res.error = 1'b1;
                end
            end else if (r_phase != PH_PLAIN) begin
                act.res.error = 1'b1;
            end
            n_phase = PH_PLAIN;
            n_acc   = 8'd0;
            n_first = 4'd0;
            n_err   = 1'b0;
        end
    end

    assign o_act = act;

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_acc   <= 8'd0;
            r_first <= 4'd0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_first <= n_first;
            r_err   <= n_err;
        end
    end

endmodule
